FILE: rtl/core/char_lcd_shadow_writer_unit_assert.svh
// Assertion macros shared by the character display writer modules.
`ifndef CHAR_LCD_SHADOW_WRITER_UNIT_ASSERT_SVH
`define CHAR_LCD_SHADOW_WRITER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CLSW_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CLSW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/clsw_pkg.sv
// Types, constants and helpers for the character display writer.
package clsw_pkg;

    localparam int LINE_CELLS  = 16;
    localparam int TOTAL_CELLS = 32;
    localparam int CELL_AW     = $clog2(TOTAL_CELLS);

    localparam logic [1:0] OP_PRINT   = 2'd0;
    localparam logic [1:0] OP_SET_POS = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    localparam logic [7:0] SPACE_CODE     = 8'h20;
    localparam logic [7:0] NEWLINE_CODE   = 8'h0A;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_HOME       = 8'h02;
    localparam logic [7:0] CMD_DDRAM      = 8'h80;
    localparam logic [7:0] LINE_TWO_BASE  = 8'h40;
    localparam logic [7:0] CURSOR_UNKNOWN = 8'hFF;

    typedef struct packed {
        logic [1:0]         op;
        logic [7:0]         char_code;
        logic [CELL_AW-1:0] position;
    } item_t;

    typedef struct packed {
        logic       is_data;
        logic [7:0] value;
    } word_t;

    typedef struct packed {
        logic [2:0]      count;
        word_t [3:0]     words;
        logic [5:0]      write_position;
    } bundle_t;

    function automatic logic [7:0] ddram_cmd(input logic [CELL_AW-1:0] p);
        logic [7:0] p8;
        p8 = 8'(p);
        if (p8 < 8'(LINE_CELLS))
            return CMD_DDRAM | p8;
        else
            return CMD_DDRAM | (p8 - 8'(LINE_CELLS) + LINE_TWO_BASE);
    endfunction

endpackage

FILE: rtl/core/char_lcd_shadow_writer_unit.sv
// Top level of the two-line character display writer with screen shadow.
// Each item is registered at the input, then its words load into the output buffer.
// Throughput: one item per cycle while each sends at most one word and m_tready is high;
// an item with more words (up to 3) holds the output buffer until its last word is taken.
// Items that send nothing retire without using or waiting for the output buffer.
// Reset: positions and flags clear at once; shadow valid bits clear, cells read as spaces.
module char_lcd_shadow_writer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] char_code, [12:8] position, [15:13] zero
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] value, [13:8] write_position, [15:14] zero
    output logic        m_tuser,   // [0] is_data
    output logic        m_tlast
);

    logic              s1_valid_reg;
    clsw_pkg::item_t   s1_item_reg;
    clsw_pkg::bundle_t bundle;
    logic              obuf_free;
    logic              adv;
    logic              load;

    assign adv      = s1_valid_reg && (bundle.count == 3'd0 || obuf_free);
    assign load     = adv && (bundle.count != 3'd0);
    assign s_tready = !s1_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_tready)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_item_reg.op        <= s_tuser;
            s1_item_reg.char_code <= s_tdata[7:0];
            s1_item_reg.position  <= s_tdata[12:8];
        end
    end

    clsw_step u_step
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (s1_item_reg),
        .adv    (adv),
        .bundle (bundle)
    );

    clsw_obuf u_obuf
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .bundle   (bundle),
        .free     (obuf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: rtl/core/clsw_step.sv
// Screen shadow, position state and per-item bus word generation.
`include "char_lcd_shadow_writer_unit_assert.svh"

module clsw_step
(
    input  logic              clk,
    input  logic              rst_n,
    input  clsw_pkg::item_t   item,
    input  logic              adv,
    output clsw_pkg::bundle_t bundle
);

    logic [7:0]                      shadow_reg [clsw_pkg::TOTAL_CELLS];
    logic [clsw_pkg::TOTAL_CELLS-1:0] valid_reg;
    logic [5:0]                      write_pos_reg;
    logic [7:0]                      cursor_pos_reg;
    logic                            clear_pending_reg;

    logic [clsw_pkg::TOTAL_CELLS-1:0] valid_next;
    logic [5:0]                  write_pos_next;
    logic [7:0]                  cursor_pos_next;
    logic                        clear_pending_next;
    logic                        do_clear;
    logic                        do_addr;
    logic                        do_data;
    logic                        cell_wr;
    logic [clsw_pkg::CELL_AW-1:0] cell_idx;
    logic [clsw_pkg::CELL_AW-1:0] addr_pos;
    logic [7:0]                  cell_val;
    logic [2:0]                  n;

    always_comb
    begin
        write_pos_next     = write_pos_reg;
        cursor_pos_next    = cursor_pos_reg;
        clear_pending_next = clear_pending_reg;
        do_clear           = 1'b0;
        do_addr            = 1'b0;
        do_data            = 1'b0;
        cell_wr            = 1'b0;
        cell_idx           = write_pos_reg[clsw_pkg::CELL_AW-1:0];
        addr_pos           = '0;
        cell_val           = clsw_pkg::SPACE_CODE;
        case (item.op)
            clsw_pkg::OP_PRINT:
            begin
                if (clear_pending_reg)
                begin
                    do_clear           = 1'b1;
                    write_pos_next     = '0;
                    cursor_pos_next    = '0;
                    clear_pending_next = 1'b0;
                end
                if (write_pos_next >= 6'(clsw_pkg::TOTAL_CELLS))
                    write_pos_next = '0;
                if (item.char_code == clsw_pkg::NEWLINE_CODE)
                begin
                    clear_pending_next = 1'b1;
                end
                else
                begin
                    if (write_pos_next == 6'(clsw_pkg::LINE_CELLS))
                        cursor_pos_next = clsw_pkg::CURSOR_UNKNOWN;
                    cell_idx = write_pos_next[clsw_pkg::CELL_AW-1:0];
                    if (!do_clear && valid_reg[cell_idx])
                        cell_val = shadow_reg[cell_idx];
                    if (cell_val != item.char_code)
                    begin
                        cell_wr = 1'b1;
                        do_data = 1'b1;
                        if (cursor_pos_next != 8'(write_pos_next))
                        begin
                            do_addr  = 1'b1;
                            addr_pos = cell_idx;
                        end
                        cursor_pos_next = 8'(write_pos_next) + 8'd1;
                    end
                    write_pos_next = write_pos_next + 6'd1;
                end
            end
            clsw_pkg::OP_SET_POS:
            begin
                write_pos_next = 6'(item.position);
                if (8'(item.position) != cursor_pos_reg)
                begin
                    cursor_pos_next = 8'(item.position);
                    do_addr         = 1'b1;
                    addr_pos        = item.position;
                end
            end
            clsw_pkg::OP_CLEAR:
            begin
                do_clear        = 1'b1;
                write_pos_next  = '0;
                cursor_pos_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        valid_next = do_clear ? '0 : valid_reg;
        if (cell_wr)
            valid_next[cell_idx] = 1'b1;
    end

    always_comb
    begin
        n            = '0;
        bundle.words = '0;
        if (do_clear)
        begin
            bundle.words[0] = '{is_data: 1'b0, value: clsw_pkg::CMD_CLEAR};
            bundle.words[1] = '{is_data: 1'b0, value: clsw_pkg::CMD_HOME};
            n = 3'd2;
        end
        if (do_addr)
        begin
            bundle.words[n[1:0]] = '{is_data: 1'b0, value: clsw_pkg::ddram_cmd(addr_pos)};
            n = n + 3'd1;
        end
        if (do_data)
        begin
            bundle.words[n[1:0]] = '{is_data: 1'b1, value: item.char_code};
            n = n + 3'd1;
        end
        bundle.count          = n;
        bundle.write_position = write_pos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg         <= '0;
            write_pos_reg     <= '0;
            cursor_pos_reg    <= '0;
            clear_pending_reg <= 1'b0;
        end
        else if (adv)
        begin
            write_pos_reg     <= write_pos_next;
            cursor_pos_reg    <= cursor_pos_next;
            clear_pending_reg <= clear_pending_next;
            valid_reg         <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && cell_wr)
            shadow_reg[cell_idx] <= item.char_code;
    end

    `CLSW_ASSERT(a_wpos_range, 1'b1, write_pos_reg <= 6'(clsw_pkg::TOTAL_CELLS),
        "write position beyond screen")
    `CLSW_ASSERT_NEXT(a_clear_home, adv && item.op == clsw_pkg::OP_CLEAR,
        write_pos_reg == '0 && cursor_pos_reg == '0 && valid_reg == '0,
        "clear did not home and blank the shadow")

endmodule

FILE: rtl/core/clsw_obuf.sv
// Output buffer that sends the bus words of one item, one word per cycle while the receiver is ready.
`include "char_lcd_shadow_writer_unit_assert.svh"

module clsw_obuf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  clsw_pkg::bundle_t bundle,
    output logic              free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [7:0] value, [13:8] write_position, [15:14] zero
    output logic              m_tuser,   // [0] is_data
    output logic              m_tlast
);

    logic                  buf_valid_reg;
    logic [1:0]            idx_reg;
    logic [1:0]            last_reg;
    clsw_pkg::word_t [3:0] words_reg;
    logic [5:0]            wpos_reg;

    logic at_last;

    assign at_last  = (idx_reg == last_reg);
    assign free     = !buf_valid_reg || (m_tready && at_last);
    assign m_tvalid = buf_valid_reg;
    assign m_tlast  = at_last;
    assign m_tuser  = words_reg[idx_reg].is_data;
    assign m_tdata  = {2'b00, wpos_reg, words_reg[idx_reg].value};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            idx_reg       <= '0;
            last_reg      <= '0;
        end
        else if (load)
        begin
            buf_valid_reg <= 1'b1;
            idx_reg       <= '0;
            last_reg      <= bundle.count[1:0] - 2'd1;
        end
        else if (buf_valid_reg && m_tready)
        begin
            if (at_last)
                buf_valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            words_reg <= bundle.words;
            wpos_reg  <= bundle.write_position;
        end
    end

    `CLSW_ASSERT(a_load_free, load, !buf_valid_reg || (m_tready && at_last),
        "buffer loaded while words remain")
    `CLSW_ASSERT(a_idx_range, buf_valid_reg, idx_reg <= last_reg, "word index past last")
    `CLSW_ASSERT_NEXT(a_drain, buf_valid_reg && m_tready && at_last && !load,
        !buf_valid_reg, "buffer not released after last word")

endmodule

FILE: sim/char_lcd_shadow_writer_unit_checker.sv
// Checker for the character display writer: predicts the bus words and compares them.
module char_lcd_shadow_writer_unit_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] char_code, [12:8] position, [15:13] zero
    input  logic [1:0]  s_tuser,   // [1:0] op
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [7:0] value, [13:8] write_position, [15:14] zero
    input  logic        m_tuser,   // [0] is_data
    input  logic        m_tlast,
    output int          failures,
    output int          pending
);

    localparam int MAX_REPORTS = 60;

    typedef struct {
        logic       is_data;
        logic [7:0] value;
        logic       last;
        logic [5:0] write_position;
    } bus_write_t;

    logic [7:0]       screen [clsw_pkg::TOTAL_CELLS];
    logic [5:0]       write_pos;
    logic [7:0]       cursor;
    logic             clear_armed;
    int               fail_count;
    clsw_pkg::word_t  item_words [$];
    bus_write_t       expected_writes [$];

    function automatic logic [7:0] ddram_address(input logic [5:0] p);
        if (p < 6'(clsw_pkg::LINE_CELLS))
            return clsw_pkg::CMD_DDRAM | 8'(p);
        return clsw_pkg::CMD_DDRAM
               | (8'(p) + clsw_pkg::LINE_TWO_BASE - 8'(clsw_pkg::LINE_CELLS));
    endfunction

    task automatic send_word(input logic is_data, input logic [7:0] value);
        item_words.push_back({is_data, value});
    endtask

    task automatic clear_screen();
        send_word(1'b0, clsw_pkg::CMD_CLEAR);
        send_word(1'b0, clsw_pkg::CMD_HOME);
        foreach (screen[i])
            screen[i] = clsw_pkg::SPACE_CODE;
        write_pos = '0;
        cursor    = '0;
    endtask

    task automatic move_to(input logic [5:0] p);
        write_pos = p;
        if (8'(p) != cursor)
        begin
            cursor = 8'(p);
            send_word(1'b0, ddram_address(p));
        end
    endtask

    task automatic print_char(input logic [7:0] ch);
        if (clear_armed)
        begin
            clear_screen();
            clear_armed = 1'b0;
        end
        if (write_pos >= 6'(clsw_pkg::TOTAL_CELLS))
            write_pos = '0;
        if (ch == clsw_pkg::NEWLINE_CODE)
            clear_armed = 1'b1;
        else
        begin
            // start of line two: controller cursor position is not trusted
            if (write_pos == 6'(clsw_pkg::LINE_CELLS))
                cursor = clsw_pkg::CURSOR_UNKNOWN;
            if (screen[write_pos] != ch)
            begin
                screen[write_pos] = ch;
                if (cursor != 8'(write_pos))
                    move_to(write_pos);
                send_word(1'b1, ch);
                cursor = cursor + 8'd1;
            end
            write_pos = write_pos + 6'd1;
        end
    endtask

    task automatic predict_item(input logic [1:0] op, input logic [7:0] ch,
                                input logic [4:0] pos);
        clsw_pkg::word_t w;
        item_words.delete();
        case (op)
            clsw_pkg::OP_PRINT:   print_char(ch);
            clsw_pkg::OP_SET_POS: move_to(6'(pos));
            clsw_pkg::OP_CLEAR:   clear_screen();
            default:              ;
        endcase
        foreach (item_words[k])
        begin
            w = item_words[k];
            expected_writes.push_back('{w.is_data, w.value,
                                        k == item_words.size() - 1, write_pos});
        end
    endtask

    task automatic report(input string field, input int exp_v, input int act_v);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $error("%s: expected %0h, got %0h", field, exp_v, act_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bus_write_t exp_w;
        if (!rst_n)
        begin
            foreach (screen[i])
                screen[i] = clsw_pkg::SPACE_CODE;
            write_pos   = '0;
            cursor      = '0;
            clear_armed = 1'b0;
            fail_count  = 0;
            expected_writes.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_item(s_tuser, s_tdata[7:0], s_tdata[12:8]);
            if (m_tvalid && m_tready)
            begin
                if (expected_writes.size() == 0)
                    report("unexpected word value", -1, m_tdata[7:0]);
                else
                begin
                    exp_w = expected_writes.pop_front();
                    if (m_tuser !== exp_w.is_data)
                        report("is_data", exp_w.is_data, m_tuser);
                    if (m_tdata[7:0] !== exp_w.value)
                        report("value", exp_w.value, m_tdata[7:0]);
                    if (m_tlast !== exp_w.last)
                        report("last", exp_w.last, m_tlast);
                    if (m_tdata[13:8] !== exp_w.write_position)
                        report("write_position", exp_w.write_position, m_tdata[13:8]);
                end
            end
        end
        failures <= fail_count;
        pending  <= expected_writes.size();
    end

endmodule

FILE: sim/char_lcd_shadow_writer_unit_tb.sv
// Testbench top for the character display writer: stimulus, handshake gaps and verdict.
module char_lcd_shadow_writer_unit_tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS      = 280;
    localparam int QUIET_TAIL        = 60;
    localparam int WATCHDOG_LIMIT    = 2000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int failures;
    int pending;
    int quiet_cycles;
    bit gaps_enabled = 1'b1;

    char_lcd_shadow_writer_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    char_lcd_shadow_writer_unit_checker lcd_check
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .failures (failures),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic push_item(input logic [1:0] op, input logic [7:0] ch,
                             input logic [4:0] pos);
        if (gaps_enabled && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, pos, ch};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // receiver stalls
    initial
    begin
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (gaps_enabled && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int         counted;
        int         roll;
        logic [1:0] op;
        logic [7:0] ch;
        logic [4:0] pos;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= clsw_pkg::OP_PRINT;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_item(clsw_pkg::OP_PRINT,   8'h41, 5'd0);
        push_item(clsw_pkg::OP_SET_POS, 8'h00, 5'd0);
        push_item(clsw_pkg::OP_PRINT,   8'h41, 5'd31);   // same as the cell: nothing sent
        push_item(clsw_pkg::OP_SET_POS, 8'hFF, 5'd15);
        push_item(clsw_pkg::OP_PRINT,   8'h00, 5'd0);
        push_item(clsw_pkg::OP_PRINT,   8'hFF, 5'd0);    // start of line two
        push_item(clsw_pkg::OP_SET_POS, 8'h00, 5'd31);
        push_item(clsw_pkg::OP_PRINT,   8'h7E, 5'd0);
        push_item(clsw_pkg::OP_PRINT,   8'h80, 5'd0);    // wraps past the last cell
        push_item(clsw_pkg::OP_PRINT,   clsw_pkg::SPACE_CODE, 5'd0);
        push_item(clsw_pkg::OP_SET_POS, 8'h00, 5'd2);
        push_item(clsw_pkg::OP_SET_POS, 8'h00, 5'd2);
        push_item(clsw_pkg::OP_PRINT,   clsw_pkg::NEWLINE_CODE, 5'd0);
        push_item(clsw_pkg::OP_PRINT,   clsw_pkg::NEWLINE_CODE, 5'd0);
        push_item(clsw_pkg::OP_PRINT,   8'h42, 5'd0);
        push_item(clsw_pkg::OP_PRINT,   clsw_pkg::NEWLINE_CODE, 5'd0);
        push_item(clsw_pkg::OP_CLEAR,   8'h00, 5'd0);    // armed clear survives
        push_item(clsw_pkg::OP_PRINT,   8'h43, 5'd0);
        push_item(OP_UNUSED,            8'hFF, 5'd31);
        push_item(clsw_pkg::OP_SET_POS, 8'h00, 5'd16);
        push_item(clsw_pkg::OP_PRINT,   8'h55, 5'd0);
        push_item(clsw_pkg::OP_CLEAR,   8'hFF, 5'd31);
        push_item(clsw_pkg::OP_SET_POS, 8'h00, 5'd31);
        push_item(clsw_pkg::OP_PRINT,   8'h78, 5'd0);
        push_item(clsw_pkg::OP_PRINT,   clsw_pkg::NEWLINE_CODE, 5'd0);
        push_item(clsw_pkg::OP_PRINT,   8'h79, 5'd0);

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 62)
                op = clsw_pkg::OP_PRINT;
            else if (roll < 84)
                op = clsw_pkg::OP_SET_POS;
            else if (roll < 92)
                op = clsw_pkg::OP_CLEAR;
            else
                op = OP_UNUSED;

            case ($urandom_range(0, 3))
                0:       pos = 5'($urandom_range(0, 1)
                                  ? clsw_pkg::LINE_CELLS - 1 + $urandom_range(0, 1)
                                  : ($urandom_range(0, 1) ? 0 : 31));
                default: pos = 5'($urandom_range(0, 31));
            endcase

            roll = $urandom_range(0, 99);
            if (roll < 7)
                ch = clsw_pkg::NEWLINE_CODE;
            else if (roll < 55)
                ch = $urandom_range(0, 4) == 0 ? clsw_pkg::SPACE_CODE
                                               : 8'(8'h61 + $urandom_range(0, 3));
            else
                ch = 8'($urandom_range(0, 255));

            if (counted == RANDOM_ITEMS - QUIET_TAIL)
                gaps_enabled = 1'b0;
            push_item(op, ch, pos);
            if (op != OP_UNUSED)
                counted++;
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        wait (pending == 0);
        repeat (8) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/clsw_pkg.sv
rtl/core/clsw_step.sv
rtl/core/clsw_obuf.sv
rtl/core/char_lcd_shadow_writer_unit.sv
sim/char_lcd_shadow_writer_unit_checker.sv
sim/char_lcd_shadow_writer_unit_tb.sv
